FILE: design/gvp_pkg.sv
// Shared types, constants and GF(2^8) arithmetic for the Vandermonde parity encoder.
// Depends on nothing; every design file imports it.
package gvp_pkg;

	// Size limits of the encoder.
	localparam int MAX_DATA_SHARDS   = 16;
	localparam int MAX_PARITY_SHARDS = 8;

	// Derived widths.
	localparam int CNT_W      = (MAX_DATA_SHARDS > 1) ? $clog2(MAX_DATA_SHARDS) : 1;
	localparam int ROW_W      = (MAX_PARITY_SHARDS > 1) ? $clog2(MAX_PARITY_SHARDS) : 1;
	localparam int D_CFG_W    = 5;
	localparam int P_CFG_W    = 4;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 2;

	// Field polynomial 0x11D without its top bit.
	localparam logic [7:0] GF_POLY_LOW = 8'h1D;

	typedef logic [7:0]            gf_byte_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [ROW_W-1:0]      row_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_DATA_SHARDS   = 2'd0;
	localparam cfg_idx_t REG_PARITY_SHARDS = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [D_CFG_W-1:0] D_CFG_RESET = 5'd4;
	localparam logic [P_CFG_W-1:0] P_CFG_RESET = 4'd2;

	// Control of one parity row: clear restarts the column, step takes a byte.
	typedef struct packed {
		logic step;
		logic clear;
	} row_ctrl_t;

	// Shift-and-add multiply in GF(2^8), eight narrow steps.
	function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
		gf_byte_t x;
		gf_byte_t r;
		x = a;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				r = r ^ x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LOW) : {x[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: design/gf256_vandermonde_parity_encoder.sv
// Top level of the GF(2^8) Vandermonde parity encoder (polynomial 0x11D).
// Depends on gvp_pkg and gvp_row_mac.
//
// Data bytes enter column by column, shard 0 first, one byte per cycle. Every
// parity row multiplies the byte by its running power and adds it into its
// accumulator in the cycle the request is taken. The last byte of a column copies
// all row results into a snapshot register, which drains one parity byte per
// cycle while out_stall is low, row 0 first, with column_last on the final row.
// The next column accumulates while the snapshot drains; the last byte of a
// column is stalled while the previous snapshot still holds bytes, unless its
// final byte is taken in that same cycle. A write to a shard-count register
// restarts the current column and must be made only while the block is idle.
module gf256_vandermonde_parity_encoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  gvp_pkg::cfg_idx_t    cfg_index,
	input  gvp_pkg::cfg_data_t   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  gvp_pkg::gf_byte_t    data_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output gvp_pkg::gf_byte_t    parity_byte,
	output gvp_pkg::row_idx_t    parity_row,
	output logic                 column_last
);
	import gvp_pkg::*;

	logic [D_CFG_W-1:0] d_cfg_q;
	logic [P_CFG_W-1:0] p_cfg_q;
	logic               cfg_hit;
	logic [CNT_W-1:0]   d_m1;
	row_idx_t           p_m1;
	gf_byte_t           d_eff;
	logic [CNT_W-1:0]   cnt_q;
	logic               col_end;
	logic               in_fire;
	logic               out_fire;
	logic               snap_free;
	logic               busy_q;
	row_idx_t           idx_q;
	row_idx_t           last_row_q;
	row_ctrl_t          row_ctrl;
	gf_byte_t           acc_nxt [MAX_PARITY_SHARDS];
	gf_byte_t           snap_q  [MAX_PARITY_SHARDS];

	// Configuration registers.
	assign cfg_hit = cfg_we && ((cfg_index == REG_DATA_SHARDS) ||
		(cfg_index == REG_PARITY_SHARDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_cfg_q <= D_CFG_RESET;
			p_cfg_q <= P_CFG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_DATA_SHARDS) begin
				d_cfg_q <= cfg_data[D_CFG_W-1:0];
			end else if (cfg_index == REG_PARITY_SHARDS) begin
				p_cfg_q <= cfg_data[P_CFG_W-1:0];
			end
		end
	end

	// Effective shard counts: zero acts as one, large values saturate.
	always_comb begin
		if (d_cfg_q == '0) begin
			d_m1 = '0;
		end else if (32'(d_cfg_q) > MAX_DATA_SHARDS) begin
			d_m1 = CNT_W'(MAX_DATA_SHARDS - 1);
		end else begin
			d_m1 = CNT_W'(d_cfg_q - 5'd1);
		end
		if (p_cfg_q == '0) begin
			p_m1 = '0;
		end else if (32'(p_cfg_q) > MAX_PARITY_SHARDS) begin
			p_m1 = ROW_W'(MAX_PARITY_SHARDS - 1);
		end else begin
			p_m1 = ROW_W'(p_cfg_q - 4'd1);
		end
	end

	assign d_eff = 8'(d_m1) + 8'd1;

	// Handshakes. The snapshot may be reloaded in the cycle its final byte leaves.
	assign out_valid = busy_q;
	assign out_fire  = out_valid && !out_stall;
	assign snap_free = !busy_q || (out_fire && column_last);
	assign col_end   = (cnt_q >= d_m1);
	assign in_stall  = col_end && !snap_free;
	assign in_fire   = in_valid && !in_stall;

	// Shard position within the column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_hit) begin
			cnt_q <= '0;
		end else if (in_fire) begin
			cnt_q <= col_end ? '0 : cnt_q + 1'b1;
		end
	end

	// Parity rows, each with base (row + D).
	assign row_ctrl.step  = in_fire;
	assign row_ctrl.clear = cfg_hit || (in_fire && col_end);

	for (genvar i = 0; i < MAX_PARITY_SHARDS; i++) begin : g_row
		gvp_row_mac u_row (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (row_ctrl),
			.data_byte (data_byte),
			.base      (8'(i) + d_eff),
			.acc_nxt   (acc_nxt[i])
		);
	end

	// Snapshot control: load on a column end, advance one row per taken result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			last_row_q <= '0;
		end else if (in_fire && col_end) begin
			busy_q     <= 1'b1;
			idx_q      <= '0;
			last_row_q <= p_m1;
		end else if (out_fire) begin
			if (column_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Snapshot payload of the finished column.
	always_ff @(posedge clk) begin
		if (in_fire && col_end) begin
			for (int i = 0; i < MAX_PARITY_SHARDS; i++) begin
				snap_q[i] <= acc_nxt[i];
			end
		end
	end

	// Result fields come straight from the snapshot.
	assign parity_byte = snap_q[idx_q];
	assign parity_row  = idx_q;
	assign column_last = (idx_q == last_row_q);

`ifndef NO_ASSERTIONS
	// A column end is never taken while earlier parity bytes still wait.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && col_end) |-> (!busy_q || (out_fire && column_last)))
		else $error("snapshot reloaded while results remain");

	// A finished column always shows its first parity row next.
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && col_end) |=> (out_valid && (parity_row == '0)))
		else $error("snapshot load did not start at row zero");

	// The drain never runs past the last row of its column.
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q <= last_row_q))
		else $error("parity row beyond the column's last row");

	// A write to a shard-count register restarts the column.
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (cnt_q == '0))
		else $error("shard counter not cleared by configuration");
`endif

endmodule

FILE: design/gvp_row_mac.sv
// One parity row: running power of the row base and the column accumulator.
// Depends on gvp_pkg for the GF(2^8) multiply and the row control struct.
module gvp_row_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  gvp_pkg::row_ctrl_t ctrl,
	input  gvp_pkg::gf_byte_t  data_byte,
	input  gvp_pkg::gf_byte_t  base,
	output gvp_pkg::gf_byte_t  acc_nxt
);
	import gvp_pkg::*;

	gf_byte_t acc_q;
	gf_byte_t pow_q;

	// Fold the incoming byte, weighted by the current power, into the row.
	assign acc_nxt = acc_q ^ gf_mul(pow_q, data_byte);

	// The power advances by the base with each stepped byte; a clear restarts the column and takes priority.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'h00;
			pow_q <= 8'h01;
		end else if (ctrl.clear) begin
			acc_q <= 8'h00;
			pow_q <= 8'h01;
		end else if (ctrl.step) begin
			acc_q <= acc_nxt;
			pow_q <= gf_mul(pow_q, base);
		end
	end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the GF(2^8) Vandermonde parity encoder.
// Depends on gvp_pkg and gf256_vandermonde_parity_encoder; a scoreboard class predicts parity.
module testbench;
	import gvp_pkg::*;

	// Indexes outside the register map; writes to them must be ignored.
	localparam cfg_idx_t REG_UNUSED_2 = 2'd2;
	localparam cfg_idx_t REG_UNUSED_3 = 2'd3;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_DELAY = 4;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_BYTES  = 18;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		gf_byte_t value;
		row_idx_t row;
		logic     last;
	} parity_result_t;

	// Column-parity predictor and result checker.
	class parity_scoreboard;
		logic [D_CFG_W-1:0] d_setting;
		logic [P_CFG_W-1:0] p_setting;
		gf_byte_t           row_sum [MAX_PARITY_SHARDS];
		gf_byte_t           row_power [MAX_PARITY_SHARDS];
		int                 shard_index;
		parity_result_t     pending_parity [$];
		int                 mismatches;
		int                 checked;

		function new();
			d_setting   = D_CFG_RESET;
			p_setting   = P_CFG_RESET;
			mismatches  = 0;
			checked     = 0;
			restart_column();
		endfunction

		function void restart_column();
			for (int i = 0; i < MAX_PARITY_SHARDS; i++) begin
				row_sum[i]   = 8'h00;
				row_power[i] = 8'h01;
			end
			shard_index = 0;
		endfunction

		// Horner-style product: walk the multiplier from its top bit down.
		function gf_byte_t gf_times(gf_byte_t a, gf_byte_t b);
			gf_byte_t acc;
			acc = 8'h00;
			for (int k = 7; k >= 0; k--) begin
				acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_POLY_LOW : 8'h00);
				if (a[k]) begin
					acc = acc ^ b;
				end
			end
			return acc;
		endfunction

		function int shards_in_use();
			if (d_setting == 0) return 1;
			if (d_setting > MAX_DATA_SHARDS) return MAX_DATA_SHARDS;
			return int'(d_setting);
		endfunction

		function int rows_in_use();
			if (p_setting == 0) return 1;
			if (p_setting > MAX_PARITY_SHARDS) return MAX_PARITY_SHARDS;
			return int'(p_setting);
		endfunction

		// Any write to a real register restarts the column.
		function void write_reg(cfg_idx_t idx, cfg_data_t value);
			if (idx == REG_DATA_SHARDS) begin
				d_setting = value[D_CFG_W-1:0];
				restart_column();
			end else if (idx == REG_PARITY_SHARDS) begin
				p_setting = value[P_CFG_W-1:0];
				restart_column();
			end
		endfunction

		// Fold one accepted data request into every row; queue parity at column end.
		function void take_byte(gf_byte_t data);
			int             d;
			int             p;
			gf_byte_t       base;
			parity_result_t res;
			d = shards_in_use();
			p = rows_in_use();
			for (int i = 0; i < p; i++) begin
				base         = 8'(i + d);
				row_sum[i]   = row_sum[i] ^ gf_times(row_power[i], data);
				row_power[i] = gf_times(row_power[i], base);
			end
			if (shard_index + 1 >= d) begin
				for (int i = 0; i < p; i++) begin
					res.value = row_sum[i];
					res.row   = row_idx_t'(i);
					res.last  = (i + 1 == p);
					pending_parity.insert(pending_parity.size(), res);
				end
				restart_column();
			end else begin
				shard_index++;
			end
		endfunction

		// Compare one accepted parity request against the oldest prediction.
		function void check_parity(gf_byte_t value, row_idx_t row, logic last);
			parity_result_t want;
			checked++;
			if (pending_parity.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("ERROR: unexpected parity byte %h row %0d last %b",
						value, row, last);
				end
			end else begin
				want = pending_parity.pop_front();
				if (want.value !== value || want.row !== row || want.last !== last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("ERROR: expected byte %h row %0d last %b, got byte %h row %0d last %b",
							want.value, want.row, want.last, value, row, last);
					end
				end
			end
		endfunction
	endclass

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      cfg_we      = 1'b0;
	cfg_idx_t  cfg_index   = '0;
	cfg_data_t cfg_data    = '0;
	logic      in_valid    = 1'b0;
	logic      in_stall;
	gf_byte_t  data_byte   = '0;
	logic      out_valid;
	logic      out_stall   = 1'b0;
	gf_byte_t  parity_byte;
	row_idx_t  parity_row;
	logic      column_last;

	parity_scoreboard sb = new();
	logic             quiet_phase = 1'b0;
	int               cycles      = 0;
	int               bytes_sent  = 0;
	int               reg_writes  = 0;

	gf256_vandermonde_parity_encoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.parity_byte (parity_byte),
		.parity_row  (parity_row),
		.column_last (column_last)
	);

	always #2 clk = ~clk;

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int draw_gap();
		return quiet_phase ? 0 : $urandom_range(0, 5);
	endfunction

	// Offer one data request after a random gap; starts and ends at a falling edge.
	task automatic send_byte(gf_byte_t value);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= value;
		do @(posedge clk); while (in_stall);
		sb.take_byte(value);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Drop the data request and wait until every predicted parity byte has drained.
	task automatic wait_idle(int extra);
		in_valid <= 1'b0;
		while (sb.pending_parity.size() != 0) @(posedge clk);
		@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Single register write while the block is idle.
	task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		sb.write_reg(idx, value);
		reg_writes++;
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic gf_byte_t random_byte();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 1) return 8'h00;
		if (pick < 2) return 8'hFF;
		return gf_byte_t'($urandom_range(0, 255));
	endfunction

	// Parity receiver: random back-pressure per parity request.
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_parity(parity_byte, parity_row, column_last);
			@(negedge clk);
		end
	end

	// Main sequence: directed cases, then randomized phases.
	initial begin
		int d_raw;
		int p_raw;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// One column with the reset shard counts.
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h01);
		wait_idle(SETTLE_DELAY);

		// Zero counts behave as one shard and one row.
		write_reg(REG_DATA_SHARDS, 5'd0);
		write_reg(REG_PARITY_SHARDS, 5'd0);
		send_byte(8'hFF);
		send_byte(8'h55);
		wait_idle(SETTLE_DELAY);

		// Oversized counts saturate; the unused top bit of the parity write is dropped.
		write_reg(REG_DATA_SHARDS, 5'h1F);
		write_reg(REG_PARITY_SHARDS, 5'h1F);
		for (int k = 0; k < MAX_DATA_SHARDS; k++) begin
			send_byte(k[0] ? 8'h01 : 8'hFF);
		end
		wait_idle(SETTLE_DELAY);

		// A write to an unused index leaves a half-done column alone.
		write_reg(REG_DATA_SHARDS, 5'd2);
		write_reg(REG_PARITY_SHARDS, 5'd1);
		send_byte(8'hAA);
		wait_idle(SETTLE_DELAY);
		write_reg(REG_UNUSED_2, 5'h1F);
		send_byte(8'h5A);
		wait_idle(SETTLE_DELAY);

		// A real register write in the middle of a column restarts it.
		send_byte(8'h3C);
		wait_idle(SETTLE_DELAY);
		write_reg(REG_DATA_SHARDS, 5'd2);
		send_byte(8'hC3);
		send_byte(8'h7E);
		wait_idle(SETTLE_DELAY);

		// Random phases; the first three pin the count extremes.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					d_raw = 1;
					p_raw = MAX_PARITY_SHARDS;
				end
				1: begin
					d_raw = MAX_DATA_SHARDS;
					p_raw = 1;
				end
				2: begin
					d_raw = 0;
					p_raw = 15;
				end
				default: begin
					d_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
						: $urandom_range(1, 5);
					p_raw = $urandom_range(0, 15);
				end
			endcase
			quiet_phase = (ph % 4 == 3);
			write_reg(REG_DATA_SHARDS, cfg_data_t'(d_raw));
			write_reg(REG_PARITY_SHARDS, cfg_data_t'(p_raw) | cfg_data_t'($urandom_range(0, 1) << 4));
			for (int k = 0; k < PHASE_BYTES; k++) begin
				send_byte(random_byte());
				// Occasionally poke an unused index halfway through the phase.
				if (k == PHASE_BYTES / 2 && $urandom_range(0, 1) == 1) begin
					wait_idle(SETTLE_DELAY);
					write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
						cfg_data_t'($urandom_range(0, 31)));
				end
			end
			wait_idle(SETTLE_DELAY);
		end

		quiet_phase = 1'b0;
		wait_idle(2 * SETTLE_DELAY);
		if (sb.pending_parity.size() != 0) begin
			$display("ERROR: %0d parity bytes never arrived", sb.pending_parity.size());
		end
		$display("Sent %0d data bytes over %0d register writes; checked %0d parity bytes.",
			bytes_sent, reg_writes, sb.checked);
		$display("Mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_parity.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/gvp_pkg.sv
design/gvp_row_mac.sv
design/gf256_vandermonde_parity_encoder.sv
tb/testbench.sv
